### hdl/touch_contact_frame_assembler_macros.svh
// Assertion macros used by the touch contact frame assembler datapath.
`ifndef TOUCH_CONTACT_FRAME_ASSEMBLER_MACROS_SVH
`define TOUCH_CONTACT_FRAME_ASSEMBLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCFA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tcfa_pkg.sv
// Types and constants shared by the touch contact frame assembler modules.
`timescale 1ns / 1ps

package tcfa_pkg;

  localparam int unsigned MaxContacts = 8;
  localparam int unsigned CntW        = $clog2(MaxContacts + 1);
  localparam int unsigned IdxW        = (MaxContacts > 1) ? $clog2(MaxContacts) : 1;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_CONTACT = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK            = 2'd0,
    STATUS_MISMATCH_WARN = 2'd1,
    STATUS_MISMATCH_ERR  = 2'd2,
    STATUS_OVERFLOW      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EMIT = 2'd2
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         contact_count;
    logic [7:0]         contact_id;
    logic [7:0]         collection_link;
    logic               is_touch;
    logic               confidence;
    logic [15:0]        logical_x;
    logic [15:0]        logical_y;
    logic signed [31:0] physical_x;
    logic signed [31:0] physical_y;
  } in_item_t;

  typedef struct packed {
    logic               has_contact;
    logic [7:0]         out_contact_id;
    logic [7:0]         out_link;
    logic               out_is_touch;
    logic               out_confidence;
    logic [15:0]        out_logical_x;
    logic [15:0]        out_logical_y;
    logic signed [31:0] out_physical_x;
    logic signed [31:0] out_physical_y;
    status_e            frame_status;
    logic               last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         id;
    logic [7:0]         link;
    logic               touch;
    logic               conf;
    logic [15:0]        lx;
    logic [15:0]        ly;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } buf_entry_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] lx;
    logic [15:0] ly;
  } prev_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic scan;
    logic emit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic finish_now;
    logic scan_last;
    logic emit_last;
    logic out_free;
  } dp_sts_t;

endpackage

### hdl/tcfa_ctrl.sv
// Controller state machine of the touch contact frame assembler.
`timescale 1ns / 1ps

module tcfa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  tcfa_pkg::dp_sts_t  sts_i,
  output logic               in_ready_o,
  output tcfa_pkg::ctl_cmd_t cmd_o
);

  tcfa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcfa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcfa_pkg::ST_IDLE: begin
        if (in_valid_i && sts_i.finish_now) begin
          state_d = tcfa_pkg::ST_SCAN;
        end
      end
      tcfa_pkg::ST_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = tcfa_pkg::ST_EMIT;
        end
      end
      tcfa_pkg::ST_EMIT: begin
        if (sts_i.out_free && sts_i.emit_last) begin
          state_d = tcfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      tcfa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      tcfa_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      tcfa_pkg::ST_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### hdl/tcfa_datapath.sv
// Datapath of the touch contact frame assembler: frame state, buffers and output register.
`timescale 1ns / 1ps
`include "touch_contact_frame_assembler_macros.svh"

module tcfa_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcfa_pkg::in_item_t in_data_i,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               out_ready_i,
  input  tcfa_pkg::ctl_cmd_t cmd_i,
  output tcfa_pkg::dp_sts_t  sts_o,
  output logic               out_valid_o,
  output tcfa_pkg::out_item_t out_data_o
);

  localparam logic [tcfa_pkg::CntW-1:0] Full = tcfa_pkg::CntW'(tcfa_pkg::MaxContacts);

  logic                      strict_q;
  logic [7:0]                expected_q, expected_d;
  logic                      ignore_q, ignore_d;
  logic [tcfa_pkg::CntW-1:0] buffered_q, buffered_d;
  logic                      overflowed_q, overflowed_d;
  logic [tcfa_pkg::CntW-1:0] prev_count_q, prev_count_d;
  logic [tcfa_pkg::CntW-1:0] idx_q, idx_d;
  logic [tcfa_pkg::CntW-1:0] keep_q, keep_d;
  logic                      out_valid_q, out_valid_d;
  tcfa_pkg::out_item_t       out_data_q, out_data_d;

  tcfa_pkg::buf_entry_t      buf_q [tcfa_pkg::MaxContacts];
  tcfa_pkg::prev_entry_t     prev_q [tcfa_pkg::MaxContacts];

  logic                      buf_we;
  logic [tcfa_pkg::IdxW-1:0] buf_waddr;
  tcfa_pkg::buf_entry_t      buf_wdata;
  logic                      prev_we;

  tcfa_pkg::buf_entry_t      cur;
  logic                      seen;
  logic                      keep_it;
  logic                      frame_open;
  logic                      finish_now;
  logic [tcfa_pkg::CntW-1:0] idx_inc;
  tcfa_pkg::status_e         status;
  tcfa_pkg::buf_entry_t      in_entry;

  assign cur        = buf_q[idx_q[tcfa_pkg::IdxW-1:0]];
  assign idx_inc    = idx_q + 1'b1;
  assign frame_open = (expected_q != 8'd0);

  assign in_entry.id    = in_data_i.contact_id;
  assign in_entry.link  = in_data_i.collection_link;
  assign in_entry.touch = in_data_i.is_touch;
  assign in_entry.conf  = in_data_i.confidence;
  assign in_entry.lx    = in_data_i.logical_x;
  assign in_entry.ly    = in_data_i.logical_y;
  assign in_entry.px    = in_data_i.physical_x;
  assign in_entry.py    = in_data_i.physical_y;

  // An end of report closes the frame once enough contacts are buffered or some were lost.
  assign finish_now = (in_data_i.kind == tcfa_pkg::KIND_END) && !ignore_q && frame_open &&
                      ((8'(buffered_q) >= expected_q) || overflowed_q);

  // Match against the previous frame, which stays untouched until the emit phase.
  always_comb begin
    seen = 1'b0;
    for (int j = 0; j < tcfa_pkg::MaxContacts; j++) begin
      if ((tcfa_pkg::CntW'(j) < prev_count_q) && (prev_q[j].id == cur.id) &&
          (prev_q[j].lx == cur.lx) && (prev_q[j].ly == cur.ly)) begin
        seen = 1'b1;
      end
    end
  end

  assign keep_it = cur.touch || seen;

  always_comb begin
    if (overflowed_q) begin
      status = tcfa_pkg::STATUS_OVERFLOW;
    end else if (8'(keep_q) != expected_q) begin
      status = strict_q ? tcfa_pkg::STATUS_MISMATCH_ERR : tcfa_pkg::STATUS_MISMATCH_WARN;
    end else begin
      status = tcfa_pkg::STATUS_OK;
    end
  end

  assign sts_o.finish_now = finish_now;
  assign sts_o.scan_last  = (idx_inc == buffered_q);
  assign sts_o.emit_last  = (keep_q == '0) || (idx_inc == keep_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    expected_d   = expected_q;
    ignore_d     = ignore_q;
    buffered_d   = buffered_q;
    overflowed_d = overflowed_q;
    prev_count_d = prev_count_q;
    idx_d        = idx_q;
    keep_d       = keep_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_data_d   = out_data_q;
    buf_we       = 1'b0;
    buf_waddr    = buffered_q[tcfa_pkg::IdxW-1:0];
    buf_wdata    = in_entry;
    prev_we      = 1'b0;

    if (cmd_i.take) begin
      case (in_data_i.kind)
        tcfa_pkg::KIND_HEADER: begin
          ignore_d = 1'b0;
          if (!frame_open) begin
            if (in_data_i.contact_count == 8'd0) begin
              ignore_d = 1'b1;
            end else begin
              expected_d = in_data_i.contact_count;
            end
          end
        end
        tcfa_pkg::KIND_CONTACT: begin
          if (!ignore_q && frame_open) begin
            if (buffered_q >= Full) begin
              overflowed_d = 1'b1;
            end else begin
              buf_we     = 1'b1;
              buffered_d = buffered_q + 1'b1;
            end
          end
        end
        tcfa_pkg::KIND_END: begin
          if (ignore_q) begin
            ignore_d = 1'b0;
          end else if (finish_now) begin
            idx_d  = '0;
            keep_d = '0;
          end
        end
        default: begin
          ignore_d = ignore_q;
        end
      endcase
    end

    // Compaction in place: the survivor count never runs ahead of the scan index.
    if (cmd_i.scan) begin
      idx_d = sts_o.scan_last ? '0 : idx_inc;
      if (keep_it) begin
        buf_we    = 1'b1;
        buf_waddr = keep_q[tcfa_pkg::IdxW-1:0];
        buf_wdata = cur;
        keep_d    = keep_q + 1'b1;
      end
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      out_data_d.frame_status  = status;
      out_data_d.last_of_frame = sts_o.emit_last;
      if (keep_q != '0) begin
        prev_we = 1'b1;
        out_data_d.has_contact    = 1'b1;
        out_data_d.out_contact_id = cur.id;
        out_data_d.out_link       = cur.link;
        out_data_d.out_is_touch   = cur.touch;
        out_data_d.out_confidence = cur.conf;
        out_data_d.out_logical_x  = cur.lx;
        out_data_d.out_logical_y  = cur.ly;
        out_data_d.out_physical_x = cur.px;
        out_data_d.out_physical_y = cur.py;
      end
      idx_d = idx_inc;
      if (sts_o.emit_last) begin
        prev_count_d = keep_q;
        expected_d   = 8'd0;
        buffered_d   = '0;
        overflowed_d = 1'b0;
        ignore_d     = 1'b0;
        idx_d        = '0;
        keep_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q     <= 1'b0;
      expected_q   <= 8'd0;
      ignore_q     <= 1'b0;
      buffered_q   <= '0;
      overflowed_q <= 1'b0;
      prev_count_q <= '0;
      idx_q        <= '0;
      keep_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        strict_q <= cfg_wdata_i;
      end
      expected_q   <= expected_d;
      ignore_q     <= ignore_d;
      buffered_q   <= buffered_d;
      overflowed_q <= overflowed_d;
      prev_count_q <= prev_count_d;
      idx_q        <= idx_d;
      keep_q       <= keep_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (buf_we) begin
      buf_q[buf_waddr] <= buf_wdata;
    end
    if (prev_we) begin
      prev_q[idx_q[tcfa_pkg::IdxW-1:0]] <= '{id: cur.id, lx: cur.lx, ly: cur.ly};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `TCFA_ASSERT_SAME(a_emit_only_when_free, clk_i, rst_ni, cmd_i.emit,
                    !out_valid_q || out_ready_i, "result loaded over an untaken result")
  `TCFA_ASSERT_SAME(a_keep_within_buffer, clk_i, rst_ni, 1'b1,
                    keep_q <= buffered_q, "survivor count exceeds buffered count")
  `TCFA_ASSERT_NEXT(a_frame_closes, clk_i, rst_ni, cmd_i.emit && sts_o.emit_last,
                    buffered_q == '0 && expected_q == 8'd0 && !overflowed_q,
                    "frame state not cleared after last result")
  `TCFA_ASSERT_NEXT(a_full_sets_overflow, clk_i, rst_ni,
                    cmd_i.take && in_data_i.kind == tcfa_pkg::KIND_CONTACT && !ignore_q &&
                    frame_open && buffered_q == Full,
                    overflowed_q, "contact into full buffer did not flag overflow")

endmodule

### hdl/touch_contact_frame_assembler.sv
// Touch contact frame assembler top level: controller and datapath.
`timescale 1ns / 1ps

// Collects touchpad contacts from header, contact and end-of-report transactions into
// frames and emits each frame's surviving contacts, or one empty marker, on the output
// channel. Header, contact and non-closing end-of-report transactions are accepted one per
// cycle while the block is idle. An end of report that closes a frame blocks further input
// until the frame has been scanned and emitted, including any output stalls: the contact
// buffer is walked one entry per cycle, first to match each entry against the previous
// frame and compact the survivors, then, while the output register is free, to emit them
// through the single output register. The user must write the strict_mode register through
// cfg_we_i only while the block is idle; the block itself does not enforce this.
module touch_contact_frame_assembler (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tcfa_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tcfa_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i
);

  tcfa_pkg::ctl_cmd_t cmd;
  tcfa_pkg::dp_sts_t  sts;

  tcfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  tcfa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

### tb/tb_touch_contact_frame_assembler.sv
// Self-checking testbench for the touch contact frame assembler: random reports, scored frames.
`timescale 1ns / 1ps

module tb_touch_contact_frame_assembler;

  localparam tcfa_pkg::kind_e KindUnused    = tcfa_pkg::kind_e'(2'd3);
  localparam int              StallMax      = 18;
  localparam int              WatchdogLimit = 1000;
  localparam int              DrainCycles   = 24;
  localparam int              PhaseItems    = 80;
  localparam int              ReportLimit   = 60;

  // Tracks the open frame and the previous frame, and holds the results still owed.
  class frame_checker;
    logic                  strict_on = 1'b0;
    logic [7:0]            want_count = '0;
    bit                    skipping = 1'b0;
    int                    held = 0;
    bit                    spilled = 1'b0;
    tcfa_pkg::buf_entry_t  held_tab[tcfa_pkg::MaxContacts];
    tcfa_pkg::prev_entry_t prev_tab[tcfa_pkg::MaxContacts];
    int                    prev_n = 0;
    tcfa_pkg::out_item_t   due_results[$];
    int                    errors = 0;
    int                    results_seen = 0;
    int                    frames = 0;
    int                    empty_frames = 0;
    int                    spill_frames = 0;
    int                    mismatch_frames = 0;
    int                    carried = 0;

    function bit frame_open();
      return want_count != 0;
    endfunction

    // Returns 1 when the block acts on the transaction, which need not change its state.
    function bit note_input(tcfa_pkg::in_item_t it);
      bit                   used;
      tcfa_pkg::buf_entry_t e;
      used = 1'b0;
      case (it.kind)
        tcfa_pkg::KIND_HEADER: begin
          used = 1'b1;
          skipping = 1'b0;
          if (want_count == 0) begin
            if (it.contact_count == 0) skipping = 1'b1;
            else want_count = it.contact_count;
          end
        end
        tcfa_pkg::KIND_CONTACT: begin
          if (!skipping && want_count != 0) begin
            used = 1'b1;
            if (held >= tcfa_pkg::MaxContacts) begin
              spilled = 1'b1;
            end else begin
              e.id    = it.contact_id;
              e.link  = it.collection_link;
              e.touch = it.is_touch;
              e.conf  = it.confidence;
              e.lx    = it.logical_x;
              e.ly    = it.logical_y;
              e.px    = it.physical_x;
              e.py    = it.physical_y;
              held_tab[held] = e;
              held++;
            end
          end
        end
        tcfa_pkg::KIND_END: begin
          if (skipping) begin
            skipping = 1'b0;
            used = 1'b1;
          end else if (want_count != 0) begin
            used = 1'b1;
            if (held >= want_count || spilled) close_frame();
          end
        end
        default: ;
      endcase
      return used;
    endfunction

    function void close_frame();
      tcfa_pkg::buf_entry_t keep[tcfa_pkg::MaxContacts];
      int                   n;
      int                   i;
      int                   j;
      bit                   hit;
      tcfa_pkg::status_e    st;
      tcfa_pkg::out_item_t  o;
      n = 0;
      for (i = 0; i < held; i++) begin
        hit = 1'b0;
        for (j = 0; j < prev_n; j++) begin
          if (prev_tab[j].id == held_tab[i].id && prev_tab[j].lx == held_tab[i].lx &&
              prev_tab[j].ly == held_tab[i].ly) hit = 1'b1;
        end
        if (held_tab[i].touch || hit) begin
          if (!held_tab[i].touch) carried++;
          keep[n] = held_tab[i];
          n++;
        end
      end

      if (spilled) begin
        st = tcfa_pkg::STATUS_OVERFLOW;
        spill_frames++;
      end else if (n != want_count) begin
        st = strict_on ? tcfa_pkg::STATUS_MISMATCH_ERR : tcfa_pkg::STATUS_MISMATCH_WARN;
        mismatch_frames++;
      end else begin
        st = tcfa_pkg::STATUS_OK;
      end

      if (n == 0) begin
        o = '0;
        o.frame_status  = st;
        o.last_of_frame = 1'b1;
        due_results.insert(due_results.size(), o);
        empty_frames++;
      end else begin
        for (i = 0; i < n; i++) begin
          o = '0;
          o.has_contact    = 1'b1;
          o.out_contact_id = keep[i].id;
          o.out_link       = keep[i].link;
          o.out_is_touch   = keep[i].touch;
          o.out_confidence = keep[i].conf;
          o.out_logical_x  = keep[i].lx;
          o.out_logical_y  = keep[i].ly;
          o.out_physical_x = keep[i].px;
          o.out_physical_y = keep[i].py;
          o.frame_status   = st;
          o.last_of_frame  = (i == n - 1);
          due_results.insert(due_results.size(), o);
          prev_tab[i].id = keep[i].id;
          prev_tab[i].lx = keep[i].lx;
          prev_tab[i].ly = keep[i].ly;
        end
      end

      prev_n     = n;
      want_count = '0;
      held       = 0;
      spilled    = 1'b0;
      skipping   = 1'b0;
      frames++;
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= ReportLimit) $error("%s: expected %0h, got %0h", field, want, got);
      end
    endfunction

    function void check_result(tcfa_pkg::out_item_t got);
      tcfa_pkg::out_item_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= ReportLimit) $error("Result with no frame outstanding: %h", got);
        return;
      end
      want = due_results.pop_front();
      results_seen++;
      compare("has_contact", 64'(want.has_contact), 64'(got.has_contact));
      compare("out_contact_id", 64'(want.out_contact_id), 64'(got.out_contact_id));
      compare("out_link", 64'(want.out_link), 64'(got.out_link));
      compare("out_is_touch", 64'(want.out_is_touch), 64'(got.out_is_touch));
      compare("out_confidence", 64'(want.out_confidence), 64'(got.out_confidence));
      compare("out_logical_x", 64'(want.out_logical_x), 64'(got.out_logical_x));
      compare("out_logical_y", 64'(want.out_logical_y), 64'(got.out_logical_y));
      compare("out_physical_x", 64'(want.out_physical_x), 64'(got.out_physical_x));
      compare("out_physical_y", 64'(want.out_physical_y), 64'(got.out_physical_y));
      compare("frame_status", 64'(want.frame_status), 64'(got.frame_status));
      compare("last_of_frame", 64'(want.last_of_frame), 64'(got.last_of_frame));
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  tcfa_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  tcfa_pkg::out_item_t out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_wdata_i = 1'b0;

  bit           allow_gaps = 1'b1;
  int           rx_stall   = 0;
  int           idle_run   = 0;
  int           items_used = 0;
  frame_checker sb;

  touch_contact_frame_assembler uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Receiver back-pressure comes in random bursts.
  always @(posedge clk_i) begin
    if (rx_stall > 0) begin
      rx_stall    <= rx_stall - 1;
      out_ready_i <= 1'b0;
    end else if (allow_gaps && $urandom_range(0, 9) == 0) begin
      rx_stall    <= $urandom_range(0, StallMax - 1);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_run <= 0;
    end else if (idle_run >= WatchdogLimit) begin
      $display("Watchdog: no transaction for %0d cycles", WatchdogLimit);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  function automatic tcfa_pkg::in_item_t noise_item();
    tcfa_pkg::in_item_t it;
    it.kind            = tcfa_pkg::kind_e'($urandom_range(0, 3));
    it.contact_count   = 8'($urandom);
    it.contact_id      = 8'($urandom);
    it.collection_link = 8'($urandom);
    it.is_touch        = 1'($urandom);
    it.confidence      = 1'($urandom);
    it.logical_x       = 16'($urandom);
    it.logical_y       = 16'($urandom);
    it.physical_x      = $urandom;
    it.physical_y      = $urandom;
    return it;
  endfunction

  function automatic tcfa_pkg::in_item_t header_item(input logic [7:0] count);
    tcfa_pkg::in_item_t it;
    it = noise_item();
    it.kind = tcfa_pkg::KIND_HEADER;
    it.contact_count = count;
    return it;
  endfunction

  function automatic tcfa_pkg::in_item_t end_item();
    tcfa_pkg::in_item_t it;
    it = noise_item();
    it.kind = tcfa_pkg::KIND_END;
    return it;
  endfunction

  // A lifted contact often reuses a contact of the previous frame so that it may survive.
  function automatic tcfa_pkg::in_item_t contact_item(input bit touch);
    tcfa_pkg::in_item_t it;
    int                 pick;
    it = noise_item();
    it.kind = tcfa_pkg::KIND_CONTACT;
    it.is_touch = touch;
    if ($urandom_range(0, 3) == 0) it.contact_id = 8'($urandom_range(0, 9));
    if (!touch && sb.prev_n != 0 && $urandom_range(0, 1) == 1) begin
      pick = $urandom_range(0, sb.prev_n - 1);
      it.contact_id = sb.prev_tab[pick].id;
      it.logical_x  = sb.prev_tab[pick].lx;
      it.logical_y  = sb.prev_tab[pick].ly;
    end
    return it;
  endfunction

  function automatic tcfa_pkg::in_item_t fixed_contact(input logic [7:0] id,
                                                       input logic [7:0] link,
                                                       input logic touch, input logic conf,
                                                       input logic [15:0] lx,
                                                       input logic [15:0] ly,
                                                       input logic [31:0] px,
                                                       input logic [31:0] py);
    tcfa_pkg::in_item_t it;
    it = '0;
    it.kind            = tcfa_pkg::KIND_CONTACT;
    it.contact_id      = id;
    it.collection_link = link;
    it.is_touch        = touch;
    it.confidence      = conf;
    it.logical_x       = lx;
    it.logical_y       = ly;
    it.physical_x      = px;
    it.physical_y      = py;
    return it;
  endfunction

  // Valid is left high after a transaction; the next call either keeps it or opens a gap.
  task automatic send_item(input tcfa_pkg::in_item_t it);
    if (allow_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, StallMax)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (sb.note_input(it)) items_used++;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.due_results.size() != 0);
  endtask

  task automatic write_strict(input logic value);
    wait_for_results();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.strict_on = value;
  endtask

  task automatic run_directed();
    tcfa_pkg::in_item_t it;
    it = noise_item();
    it.kind = KindUnused;
    send_item(it);
    send_item(end_item());
    send_item(contact_item(1'b1));
    // A zero count with no frame open makes the whole report be ignored.
    send_item(header_item(8'd0));
    send_item(contact_item(1'b1));
    send_item(end_item());
    send_item(header_item(8'd1));
    send_item(fixed_contact(8'hFF, 8'hFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF,
                            32'h7FFF_FFFF, 32'h8000_0000));
    send_item(end_item());
    // The lifted contact at the previous place survives, the unknown one is dropped.
    send_item(header_item(8'd2));
    send_item(fixed_contact(8'hFF, 8'h00, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF,
                            32'h8000_0000, 32'h7FFF_FFFF));
    send_item(fixed_contact(8'h00, 8'h5A, 1'b0, 1'b1, 16'h0000, 16'h0000,
                            32'h0000_0000, 32'hFFFF_FFFF));
    send_item(end_item());
    send_item(header_item(8'd1));
    send_item(fixed_contact(8'h12, 8'h34, 1'b0, 1'b1, 16'h0000, 16'hFFFF,
                            32'h0000_0001, 32'h0000_0000));
    send_item(end_item());
    // One frame over two reports; the second header's count has no effect.
    send_item(header_item(8'd3));
    send_item(fixed_contact(8'h00, 8'h00, 1'b1, 1'b0, 16'h0000, 16'h0000,
                            32'h0000_0000, 32'h0000_0000));
    send_item(end_item());
    send_item(header_item(8'd255));
    send_item(fixed_contact(8'h01, 8'hFF, 1'b1, 1'b1, 16'h8000, 16'h0001,
                            32'hFFFF_FFFF, 32'h8000_0000));
    send_item(contact_item(1'b1));
    send_item(end_item());
  endtask

  task automatic run_frame();
    logic [7:0] count;
    int         target;
    int         sent;
    int         k;
    int         reports;
    if ($urandom_range(0, 9) == 0) count = 8'($urandom_range(tcfa_pkg::MaxContacts + 1, 255));
    else count = 8'($urandom_range(1, tcfa_pkg::MaxContacts));
    if (count > tcfa_pkg::MaxContacts) begin
      target = $urandom_range(tcfa_pkg::MaxContacts, tcfa_pkg::MaxContacts + 2);
    end else if ($urandom_range(0, 3) == 0) begin
      target = $urandom_range(0, tcfa_pkg::MaxContacts + 2);
    end else begin
      target = count;
    end
    sent = 0;
    reports = 0;
    do begin
      send_item(header_item(reports == 0 ? count : 8'($urandom)));
      if (sent < target) k = $urandom_range(1, target - sent);
      else k = $urandom_range(0, 2);
      repeat (k) send_item(contact_item($urandom_range(0, 9) < 7));
      sent += k;
      send_item(end_item());
      reports++;
    end while (sb.frame_open() && reports < 12);
  endtask

  initial begin
    int phase;
    int r;
    bit tail;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_strict(1'b0);
    run_directed();

    for (phase = 0; phase < 3; phase++) begin
      write_strict(phase[0] ? 1'b0 : 1'b1);
      while (items_used < (phase + 1) * PhaseItems) begin
        // The closing stretch of the run goes without input gaps, new receiver stalls or waits for results.
        tail = (phase == 2) && (items_used >= 3 * PhaseItems - 40);
        if (tail) allow_gaps <= 1'b0;
        else if ($urandom_range(0, 19) == 0) allow_gaps <= !allow_gaps;
        if (!tail && $urandom_range(0, 14) == 0) wait_for_results();
        r = $urandom_range(0, 99);
        if (r < 70) begin
          run_frame();
        end else if (r < 80) begin
          send_item(header_item(8'd0));
          repeat ($urandom_range(0, 3)) send_item(contact_item(1'b1));
          send_item(end_item());
        end else begin
          repeat ($urandom_range(1, 4)) send_item(noise_item());
        end
      end
    end

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d transactions the block acted on, %0d frames and %0d results,",
             items_used, sb.frames, sb.results_seen);
    $display("with strict mode off and on: %0d empty, %0d overflowed, %0d mismatched,",
             sb.empty_frames, sb.spill_frames, sb.mismatch_frames);
    $display("and %0d lifted contacts carried over from the previous frame.", sb.carried);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### touch_contact_frame_assembler.f
+incdir+hdl
hdl/tcfa_pkg.sv
hdl/tcfa_ctrl.sv
hdl/tcfa_datapath.sv
hdl/touch_contact_frame_assembler.sv
tb/tb_touch_contact_frame_assembler.sv
